>>> src/fbcr_pkg.sv
package fbcr_pkg;

   // Request kinds carried on req_tuser.
   localparam logic [3:0] OP_CTRL_WR  = 4'd0;
   localparam logic [3:0] OP_STAT_WR  = 4'd1;
   localparam logic [3:0] OP_STAT_RD  = 4'd2;
   localparam logic [3:0] OP_HTIM_WR  = 4'd3;
   localparam logic [3:0] OP_VTIM_WR  = 4'd4;
   localparam logic [3:0] OP_VBARA_WR = 4'd5;
   localparam logic [3:0] OP_VBARB_WR = 4'd6;
   localparam logic [3:0] OP_PAL_WR   = 4'd7;
   localparam logic [3:0] OP_PAL_RD   = 4'd8;
   localparam logic [3:0] OP_LINE     = 4'd9;
   localparam logic [3:0] OP_FRAME    = 4'd10;
   localparam logic [3:0] OP_ADDR     = 4'd11;
   localparam logic [3:0] OP_ERR      = 4'd12;
   localparam logic [3:0] OP_PIXEL    = 4'd13;

   // Control register bit positions.
   localparam int C_VEN   = 0;
   localparam int C_VIE   = 1;
   localparam int C_HIE   = 2;
   localparam int C_VBSIE = 3;
   localparam int C_CBSIE = 4;
   localparam int C_VBSWE = 5;
   localparam int C_CBSWE = 6;
   localparam int C_BPP_LO = 9;
   localparam int C_BPP_HI = 10;

   // Status register bit positions.
   localparam int S_SINT   = 0;
   localparam int S_VINT   = 4;
   localparam int S_HINT   = 5;
   localparam int S_AVMP   = 16;
   localparam int S_ACMP   = 17;
   localparam logic [31:0] S_INTS_MASK = 32'h0000_00F3;

   // Palette geometry: two banks.
   localparam int BANK_ENTRIES = 256;
   localparam int PAL_DEPTH    = 2 * BANK_ENTRIES;
   localparam int PAL_AW       = $clog2(PAL_DEPTH);
   localparam int PIX_W        = $clog2(BANK_ENTRIES);

   // Field widths.
   localparam int DATA_W  = 32;
   localparam int LY_W    = 16;
   localparam int BX_W    = 18;
   localparam int LB_W    = 19;
   localparam int HT_W    = 16;
   localparam int REQ_W   = 88;
   localparam int RSP_W   = 72;

   // Pixel answer: alpha forced to full.
   localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;
   localparam logic [31:0] RGB_MASK     = 32'h00FF_FFFF;

   // Result selection carried down the pipeline.
   localparam logic [2:0] SEL_ZERO  = 3'd0;
   localparam logic [2:0] SEL_STAT  = 3'd1;
   localparam logic [2:0] SEL_PAL   = 3'd2;
   localparam logic [2:0] SEL_PIXEL = 3'd3;
   localparam logic [2:0] SEL_FETCH = 3'd4;

   typedef logic [2:0] sel_type;

endpackage

>>> src/framebuffer_controller_registers.sv
// Channel   | Signals                          | Payload
// ----------+----------------------------------+-----------------------------------------
// request   | req_tvalid/req_tready/req_tdata  | tuser opcode; tdata reg_data, pal_index,
//           | req_tuser                        | line_y, byte_x, pixel_index
// response  | rsp_tvalid/rsp_tready/rsp_tdata  | read_data, fetch_address, irq_level
//
// One request is taken per cycle while responses drain; its response passes through
// the first stage and the output register. Register updates happen in the cycle a
// request is taken; the palette read and the fetch-address product are registered,
// then combined into the output register. After reset a clearing pass writes zero to
// all 512 palette words, one per cycle; req_tready stays low until it ends. A stalled
// response holds the pipeline; otherwise req_tready drops only if both stages are full.
module framebuffer_controller_registers (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // [31:0] reg_data, [40:32] pal_index, [56:41] line_y, [74:57] byte_x,
   // [82:75] pixel_index, [87:83] zero
   input  logic [fbcr_pkg::REQ_W-1:0] req_tdata,
   // [3:0] opcode
   input  logic [3:0]                req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [31:0] read_data, [63:32] fetch_address, [64] irq_level, [71:65] zero
   output logic [fbcr_pkg::RSP_W-1:0] rsp_tdata
);
   import fbcr_pkg::*;

   // Request fields.
   logic [3:0]        op;
   logic [DATA_W-1:0] data;
   logic [PAL_AW-1:0] pidx;
   logic [LY_W-1:0]   ly;
   logic [BX_W-1:0]   bx;
   logic [PIX_W-1:0]  pix;

   assign op   = req_tuser;
   assign data = req_tdata[31:0];
   assign pidx = req_tdata[40:32];
   assign ly   = req_tdata[56:41];
   assign bx   = req_tdata[74:57];
   assign pix  = req_tdata[82:75];

   // Architectural registers.
   logic [DATA_W-1:0] ctrl_ff, ctrl_in;
   logic [DATA_W-1:0] stat_ff, stat_in;
   logic [HT_W-1:0]   htim_ff, htim_in;
   logic [DATA_W-1:0] base_a_ff, base_a_in;
   logic [DATA_W-1:0] base_b_ff, base_b_in;
   logic [LB_W-1:0]   line_bytes_ff, line_bytes_in;
   logic              irq_ff, irq_in;

   // Clearing pass.
   logic              clearing_ff, clearing_in;
   logic [PAL_AW-1:0] clr_cnt_ff, clr_cnt_in;

   // First pipeline stage.
   logic              p1_valid_ff, p1_valid_in;
   sel_type           p1_sel_ff;
   logic [DATA_W-1:0] p1_stat_ff;
   logic [DATA_W-1:0] p1_prod_ff;
   logic [DATA_W-1:0] p1_base_ff;
   logic [BX_W-1:0]   p1_bx_ff;
   logic              p1_irq_ff;

   // Output register.
   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_rd_ff, out_rd_in;
   logic [DATA_W-1:0] out_fa_ff, out_fa_in;
   logic              out_irq_ff;

   // Palette memory.
   logic [DATA_W-1:0] pal_mem [0:PAL_DEPTH-1];
   logic [DATA_W-1:0] pal_rdata_ff;
   logic              pal_we;
   logic [PAL_AW-1:0] pal_waddr;
   logic [DATA_W-1:0] pal_wdata;
   logic              pal_re;
   logic [PAL_AW-1:0] pal_raddr;

   logic    advance;
   logic    accept;
   sel_type sel_in;
   logic [DATA_W-1:0] prod_in;
   logic [DATA_W-1:0] base_sel;
   logic [DATA_W-1:0] stat_wr;

   // Handshake: the first stage moves on when the output register is free or drains.
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !clearing_ff && (advance || !p1_valid_ff);
   assign accept     = req_tvalid && req_tready;

   // Status write keeps the upper bits.
   assign stat_wr = {stat_ff[31:8], data[7:0]};

   // Next register state for the request being taken.
   always_comb begin
      ctrl_in       = ctrl_ff;
      stat_in       = stat_ff;
      htim_in       = htim_ff;
      base_a_in     = base_a_ff;
      base_b_in     = base_b_ff;
      line_bytes_in = line_bytes_ff;
      irq_in        = irq_ff;
      if (accept) begin
         case (op)
            OP_CTRL_WR: begin
               // Line length latched on enable: (active pixels) * (bytes per pixel).
               if (data[C_VEN] && !ctrl_ff[C_VEN]) begin
                  line_bytes_in = (LB_W'(htim_ff) + LB_W'(1))
                                  * (LB_W'(data[C_BPP_HI:C_BPP_LO]) + LB_W'(1));
               end
               ctrl_in = data;
            end
            OP_STAT_WR: begin
               if (|(stat_ff & ~stat_wr & S_INTS_MASK)) begin
                  irq_in = 1'b0;
               end
               stat_in = stat_wr;
            end
            OP_HTIM_WR:  htim_in   = data[HT_W-1:0];
            OP_VBARA_WR: base_a_in = data;
            OP_VBARB_WR: base_b_in = data;
            OP_LINE: begin
               if (ctrl_ff[C_HIE]) begin
                  stat_in[S_HINT] = 1'b1;
                  irq_in          = 1'b1;
               end
            end
            OP_FRAME: begin
               if (ctrl_in[C_CBSWE]) begin
                  stat_in[S_ACMP]  = ~stat_in[S_ACMP];
                  ctrl_in[C_CBSWE] = 1'b0;
                  if (ctrl_in[C_CBSIE]) begin
                     irq_in = 1'b1;
                  end
               end
               if (ctrl_in[C_VBSWE]) begin
                  stat_in[S_AVMP]  = ~stat_in[S_AVMP];
                  ctrl_in[C_VBSWE] = 1'b0;
                  if (ctrl_in[C_VBSIE]) begin
                     irq_in = 1'b1;
                  end
               end
               if (ctrl_in[C_VIE]) begin
                  stat_in[S_VINT] = 1'b1;
                  irq_in          = 1'b1;
               end
            end
            OP_ERR: begin
               stat_in[S_SINT] = 1'b1;
               irq_in          = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Result selection and fetch-address product for the first stage.
   always_comb begin
      case (op)
         OP_STAT_RD: sel_in = SEL_STAT;
         OP_PAL_RD:  sel_in = SEL_PAL;
         OP_PIXEL:   sel_in = SEL_PIXEL;
         OP_ADDR:    sel_in = SEL_FETCH;
         default:    sel_in = SEL_ZERO;
      endcase
   end

   assign prod_in  = DATA_W'(35'(ly) * 35'(line_bytes_ff));
   assign base_sel = stat_ff[S_AVMP] ? base_b_ff : base_a_ff;

   // Palette port control: the clearing pass owns the write port after reset.
   assign pal_we    = clearing_ff || (accept && op == OP_PAL_WR);
   assign pal_waddr = clearing_ff ? clr_cnt_ff : pidx;
   assign pal_wdata = clearing_ff ? '0 : data;
   assign pal_re    = accept && (op inside {OP_PAL_RD, OP_PIXEL});
   assign pal_raddr = (op == OP_PIXEL) ? {stat_ff[S_ACMP], pix} : pidx;

   // Palette memory with registered read data.
   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[pal_waddr] <= pal_wdata;
      end
      if (pal_re) begin
         pal_rdata_ff <= pal_mem[pal_raddr];
      end
   end

   // Clearing pass sequencing.
   always_comb begin
      clearing_in = clearing_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + PAL_AW'(1);
         if (clr_cnt_ff == PAL_AW'(PAL_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   // Pipeline valid flags.
   assign p1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : p1_valid_ff);
   assign out_valid_in = advance ? p1_valid_ff : out_valid_ff;

   // Output formation from the first stage.
   always_comb begin
      out_rd_in = '0;
      out_fa_in = '0;
      case (p1_sel_ff)
         SEL_STAT:  out_rd_in = p1_stat_ff;
         SEL_PAL:   out_rd_in = pal_rdata_ff;
         SEL_PIXEL: out_rd_in = (pal_rdata_ff & RGB_MASK) | ALPHA_OPAQUE;
         SEL_FETCH: out_fa_in = p1_base_ff + p1_prod_ff + DATA_W'(p1_bx_ff);
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff       <= '0;
         stat_ff       <= '0;
         htim_ff       <= '0;
         base_a_ff     <= '0;
         base_b_ff     <= '0;
         line_bytes_ff <= '0;
         irq_ff        <= 1'b0;
         clearing_ff   <= 1'b1;
         clr_cnt_ff    <= '0;
         p1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         ctrl_ff       <= ctrl_in;
         stat_ff       <= stat_in;
         htim_ff       <= htim_in;
         base_a_ff     <= base_a_in;
         base_b_ff     <= base_b_in;
         line_bytes_ff <= line_bytes_in;
         irq_ff        <= irq_in;
         clearing_ff   <= clearing_in;
         clr_cnt_ff    <= clr_cnt_in;
         p1_valid_ff   <= p1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers of both stages.
   always_ff @(posedge clock) begin
      if (accept) begin
         p1_sel_ff  <= sel_in;
         p1_stat_ff <= stat_in;
         p1_prod_ff <= prod_in;
         p1_base_ff <= base_sel;
         p1_bx_ff   <= bx;
         p1_irq_ff  <= irq_in;
      end
      if (advance && p1_valid_ff) begin
         out_rd_ff  <= out_rd_in;
         out_fa_ff  <= out_fa_in;
         out_irq_ff <= p1_irq_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_irq_ff, out_fa_ff, out_rd_ff};

endmodule

>>> test/framebuffer_register_checker.sv
// Passive checker for the framebuffer register block. It keeps its own copy of
// the register and palette state, works out the response to every accepted
// request and compares each accepted response with the oldest one waiting.
module framebuffer_register_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   // [31:0] reg_data, [40:32] pal_index, [56:41] line_y, [74:57] byte_x,
   // [82:75] pixel_index, [87:83] zero
   input  logic [fbcr_pkg::REQ_W-1:0] req_tdata,
   // [3:0] opcode
   input  logic [3:0]                 req_tuser,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [31:0] read_data, [63:32] fetch_address, [64] irq_level, [71:65] zero
   input  logic [fbcr_pkg::RSP_W-1:0] rsp_tdata,
   output int                         fail_count,
   output int                         response_backlog
);

   timeunit 1ns;
   timeprecision 1ps;

   import fbcr_pkg::*;

   // Pseudocolor enable in the control word; the package does not name it.
   localparam int CTRL_PC = 11;

   typedef struct packed {
      logic [31:0] read_data;
      logic [31:0] fetch_address;
      logic        irq_level;
   } fb_response_type;

   // Shadow copy of the block state.
   logic [31:0]    control_reg;
   logic [31:0]    status_reg;
   logic [31:0]    htim_reg;
   logic [31:0]    vtim_reg;
   logic [31:0]    base_a_reg;
   logic [31:0]    base_b_reg;
   logic [31:0]    palette [PAL_DEPTH];
   logic [LB_W-1:0] line_bytes;
   logic [16:0]    rows_active;
   logic           pseudo_mode;
   logic           irq_line;

   fb_response_type pending_responses [$];

   // Applies one request to the shadow state and queues the response it causes.
   task automatic apply_register_event(input logic [3:0] op, input logic [REQ_W-1:0] payload);
      logic [31:0]  wdata;
      logic [8:0]   pidx;
      logic [15:0]  ly;
      logic [17:0]  bx;
      logic [7:0]   pix;
      logic [31:0]  next_status;
      logic [31:0]  span;
      logic [31:0]  base;
      logic [31:0]  entry;
      fb_response_type rsp;
      wdata = payload[31:0];
      pidx  = payload[40:32];
      ly    = payload[56:41];
      bx    = payload[74:57];
      pix   = payload[82:75];
      rsp   = '0;
      case (op)
         OP_CTRL_WR: begin
            // Geometry and color mode are captured only when the display turns on.
            if (wdata[C_VEN] && !control_reg[C_VEN]) begin
               span = (32'(htim_reg[15:0]) + 32'd1) * (32'(wdata[C_BPP_HI:C_BPP_LO]) + 32'd1);
               line_bytes = span[LB_W-1:0];
               span = 32'(vtim_reg[15:0]) + 32'd1;
               rows_active = span[16:0];
               pseudo_mode = wdata[CTRL_PC];
            end
            control_reg = wdata;
         end
         OP_STAT_WR: begin
            // Only the low byte is writable; clearing any pending flag drops the line.
            next_status = {status_reg[31:8], wdata[7:0]};
            if ((status_reg & ~next_status & S_INTS_MASK) != 32'd0) begin
               irq_line = 1'b0;
            end
            status_reg = next_status;
         end
         OP_STAT_RD:  rsp.read_data = status_reg;
         OP_HTIM_WR:  htim_reg = wdata;
         OP_VTIM_WR:  vtim_reg = wdata;
         OP_VBARA_WR: base_a_reg = wdata;
         OP_VBARB_WR: base_b_reg = wdata;
         OP_PAL_WR:   palette[pidx] = wdata;
         OP_PAL_RD:   rsp.read_data = palette[pidx];
         OP_LINE: begin
            if (control_reg[C_HIE]) begin
               status_reg[S_HINT] = 1'b1;
               irq_line = 1'b1;
            end
         end
         OP_FRAME: begin
            // Palette bank swap first, then video bank swap, then the vertical flag.
            if (control_reg[C_CBSWE]) begin
               status_reg[S_ACMP] = ~status_reg[S_ACMP];
               control_reg[C_CBSWE] = 1'b0;
               if (control_reg[C_CBSIE]) begin
                  irq_line = 1'b1;
               end
            end
            if (control_reg[C_VBSWE]) begin
               status_reg[S_AVMP] = ~status_reg[S_AVMP];
               control_reg[C_VBSWE] = 1'b0;
               if (control_reg[C_VBSIE]) begin
                  irq_line = 1'b1;
               end
            end
            if (control_reg[C_VIE]) begin
               status_reg[S_VINT] = 1'b1;
               irq_line = 1'b1;
            end
         end
         OP_ADDR: begin
            base = status_reg[S_AVMP] ? base_b_reg : base_a_reg;
            rsp.fetch_address = base + 32'(ly) * 32'(line_bytes) + 32'(bx);
         end
         OP_ERR: begin
            status_reg[S_SINT] = 1'b1;
            irq_line = 1'b1;
         end
         OP_PIXEL: begin
            entry = palette[{status_reg[S_ACMP], pix}];
            rsp.read_data = (entry & RGB_MASK) | ALPHA_OPAQUE;
         end
         default: ;
      endcase
      rsp.irq_level = irq_line;
      pending_responses.push_back(rsp);
   endtask

   // Both channels are sampled on the rising edge.
   always @(posedge clock) begin
      fb_response_type want;
      fb_response_type got;
      if (reset) begin
         control_reg = '0;
         status_reg  = '0;
         htim_reg    = '0;
         vtim_reg    = '0;
         base_a_reg  = '0;
         base_b_reg  = '0;
         line_bytes  = '0;
         rows_active = '0;
         pseudo_mode = 1'b0;
         irq_line    = 1'b0;
         for (int i = 0; i < PAL_DEPTH; i++) begin
            palette[i] = '0;
         end
         pending_responses.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[64]};
            if (pending_responses.size() == 0) begin
               $error("response %h arrived with no request outstanding", rsp_tdata);
               fail_count++;
            end else begin
               want = pending_responses.pop_front();
               if (got.read_data !== want.read_data) begin
                  $error("read_data: expected %h, got %h", want.read_data, got.read_data);
                  fail_count++;
               end
               if (got.fetch_address !== want.fetch_address) begin
                  $error("fetch_address: expected %h, got %h",
                         want.fetch_address, got.fetch_address);
                  fail_count++;
               end
               if (got.irq_level !== want.irq_level) begin
                  $error("irq_level: expected %b, got %b", want.irq_level, got.irq_level);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            apply_register_event(req_tuser, req_tdata);
         end
      end
      response_backlog = pending_responses.size();
   end

endmodule

>>> test/tb_framebuffer_controller_registers.sv
// Stimulus and verdict for the framebuffer register block. Checking is done by
// the checker instance that sits beside the block.
module tb_framebuffer_controller_registers;

   timeunit 1ns;
   timeprecision 1ps;

   import fbcr_pkg::*;

   // Two opcodes that the package leaves unnamed; the block ignores them.
   localparam logic [3:0] OP_SPARE_A = 4'd14;
   localparam logic [3:0] OP_SPARE_B = 4'd15;

   localparam int RANDOM_REQUESTS = 1850;
   localparam int MAX_WAIT        = 8;
   // Covers reset, the palette clearing pass and the longest gap plus stall.
   localparam int QUIET_LIMIT     = 3000;

   // Control word with every enable, both swap requests, four bytes per pixel
   // and pseudocolor on.
   localparam logic [31:0] CTRL_ALL_ON = 32'h0000_0E7F;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   // [31:0] reg_data, [40:32] pal_index, [56:41] line_y, [74:57] byte_x,
   // [82:75] pixel_index, [87:83] zero
   logic [REQ_W-1:0] req_tdata;
   // [3:0] opcode
   logic [3:0]       req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   // [31:0] read_data, [63:32] fetch_address, [64] irq_level, [71:65] zero
   logic [RSP_W-1:0] rsp_tdata;

   int               fail_count;
   int               response_backlog;
   int               quiet_cycles;
   logic             no_idle;

   framebuffer_controller_registers DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   framebuffer_register_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .fail_count       (fail_count),
      .response_backlog (response_backlog)
   );

   initial begin
      clock = 1'b0;
   end

   always #6 clock = ~clock;

   // Sends one request after a random gap and returns once it is taken.
   task automatic send_request(input logic [3:0] op, input logic [31:0] data,
                               input logic [8:0] pidx, input logic [15:0] ly,
                               input logic [17:0] bx, input logic [7:0] pix);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {5'b0, pix, bx, ly, pidx, data};
      do @(posedge clock); while (!req_tready);
   endtask

   // Response side: a random stall before each response is taken.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            @(negedge clock);
            rsp_tready = 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Watchdog on cycles in which neither channel moves.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("framebuffer_controller_registers test failed");
         $finish;
      end
   end

   initial begin
      int          sent;
      int          issued;
      int          pick;
      logic [3:0]  op;
      logic [31:0] data;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = OP_CTRL_WR;
      no_idle      = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: field extremes, every opcode, swaps, interrupt set and clear.
      send_request(OP_STAT_RD, 32'h0, 9'h0, 16'h0, 18'h0, 8'h0);
      send_request(OP_PAL_WR, 32'hFFFF_FFFF, 9'd0, 16'hFFFF, 18'h3FFFF, 8'hFF);
      send_request(OP_PAL_WR, 32'h1234_5678, 9'd511, 16'h0, 18'h0, 8'h0);
      send_request(OP_PAL_WR, 32'hA5C3_0F96, 9'd256, 16'h0, 18'h0, 8'h0);
      send_request(OP_PAL_RD, 32'h0, 9'd511, 16'h0, 18'h0, 8'h0);
      send_request(OP_PAL_RD, 32'h0, 9'd0, 16'h0, 18'h0, 8'h0);
      send_request(OP_HTIM_WR, 32'hFFFF_FFFF, 9'h0, 16'h0, 18'h0, 8'h0);
      send_request(OP_VTIM_WR, 32'hFFFF_FFFF, 9'h0, 16'h0, 18'h0, 8'h0);
      send_request(OP_VBARA_WR, 32'hFFFF_FFFF, 9'h0, 16'h0, 18'h0, 8'h0);
      send_request(OP_VBARB_WR, 32'h8000_0000, 9'h0, 16'h0, 18'h0, 8'h0);
      send_request(OP_CTRL_WR, CTRL_ALL_ON, 9'h0, 16'h0, 18'h0, 8'h0);
      // Largest line length times the largest line number wraps the address.
      send_request(OP_ADDR, 32'h0, 9'h0, 16'hFFFF, 18'h3FFFF, 8'h0);
      send_request(OP_LINE, 32'h0, 9'h0, 16'h0, 18'h0, 8'h0);
      send_request(OP_FRAME, 32'h0, 9'h0, 16'h0, 18'h0, 8'h0);
      send_request(OP_STAT_RD, 32'h0, 9'h0, 16'h0, 18'h0, 8'h0);
      send_request(OP_ADDR, 32'h0, 9'h0, 16'h1, 18'h1, 8'h0);
      // Palette bank one is active now.
      send_request(OP_PIXEL, 32'h0, 9'h0, 16'h0, 18'h0, 8'hFF);
      send_request(OP_STAT_WR, 32'hFFFF_FF00, 9'h0, 16'h0, 18'h0, 8'h0);
      send_request(OP_ERR, 32'h0, 9'h0, 16'h0, 18'h0, 8'h0);
      send_request(OP_STAT_WR, 32'h0000_00FF, 9'h0, 16'h0, 18'h0, 8'h0);
      send_request(OP_SPARE_A, 32'hFFFF_FFFF, 9'h1FF, 16'hFFFF, 18'h3FFFF, 8'hFF);
      send_request(OP_SPARE_B, 32'hFFFF_FFFF, 9'h1FF, 16'hFFFF, 18'h3FFFF, 8'hFF);
      send_request(OP_CTRL_WR, 32'h0, 9'h0, 16'h0, 18'h0, 8'h0);
      send_request(OP_CTRL_WR, 32'h0000_0001, 9'h0, 16'h0, 18'h0, 8'h0);
      send_request(OP_PIXEL, 32'h0, 9'h0, 16'h0, 18'h0, 8'h0);

      // Random part, weighted toward a running display: palette traffic,
      // line and frame events, fetch addresses and pixel lookups.
      sent   = 0;
      issued = 0;
      while (sent < RANDOM_REQUESTS) begin
         if (issued % 64 == 0) begin
            no_idle = ($urandom_range(0, 3) == 0);
         end
         pick = $urandom_range(0, 99);
         data = $urandom();
         if (pick < 8) begin
            op = OP_CTRL_WR;
         end else if (pick < 13) begin
            op = OP_STAT_WR;
            // Often rewrite the pending flags as they are, so the line stays up.
            if ($urandom_range(0, 1) == 0) begin
               data[7:0] = 8'hFF;
            end
         end else if (pick < 18) begin
            op = OP_STAT_RD;
         end else if (pick < 22) begin
            op = OP_HTIM_WR;
         end else if (pick < 26) begin
            op = OP_VTIM_WR;
         end else if (pick < 29) begin
            op = OP_VBARA_WR;
         end else if (pick < 32) begin
            op = OP_VBARB_WR;
         end else if (pick < 46) begin
            op = OP_PAL_WR;
         end else if (pick < 54) begin
            op = OP_PAL_RD;
         end else if (pick < 64) begin
            op = OP_LINE;
         end else if (pick < 72) begin
            op = OP_FRAME;
         end else if (pick < 82) begin
            op = OP_ADDR;
         end else if (pick < 85) begin
            op = OP_ERR;
         end else if (pick < 98) begin
            op = OP_PIXEL;
         end else begin
            op = (pick == 98) ? OP_SPARE_A : OP_SPARE_B;
         end
         // Short lines and frames now and then.
         if ((op == OP_HTIM_WR || op == OP_VTIM_WR) && $urandom_range(0, 3) == 0) begin
            data[15:0] = 16'($urandom_range(0, 15));
         end
         send_request(op, data, 9'($urandom_range(0, 511)), 16'($urandom_range(0, 65535)),
                      18'($urandom_range(0, 262143)), 8'($urandom_range(0, 255)));
         issued++;
         if (op != OP_SPARE_A && op != OP_SPARE_B) begin
            sent++;
         end
      end

      @(negedge clock);
      req_tvalid = 1'b0;

      // Drain: wait for every response, then wait on for stray output.
      do @(negedge clock); while (response_backlog != 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("framebuffer_controller_registers test passed");
      end else begin
         $display("framebuffer_controller_registers test failed");
      end
      $finish;
   end

endmodule
